### rtl/plmb_pkg.sv
// Shared types, constants and the log2 table for the peak level meter core.
// No dependencies; every other file in rtl/ imports this package.
package plmb_pkg;

    // Default linear level width (Q1.(N-1), full scale is 1 << (N-1))
    localparam int PLMB_LEVEL_BITS = 16;

    // Log table: depth rounded down to a power of two
    localparam int LOG_TABLE_DEPTH = 64;
    localparam int TAB_BITS        = $clog2(LOG_TABLE_DEPTH + 1) - 1;
    localparam int TAB_SIZE        = 1 << TAB_BITS;
    localparam int LOG_FRAC_BITS   = 20;

    // log2 in Q20 to 1/16 dB: 96.3296 * 2^24, result scaled by 2^-44
    localparam logic [30:0] DB_SCALE    = 31'd1616142483;
    localparam int          DB_SHIFT    = 44;

    // dB word widths: instant value (pre-saturation) and average
    localparam int INST_W = 13;
    localparam int AVG_W  = 12;

    localparam logic signed [INST_W-1:0] SILENCE_DB16 = -13'sd1920;
    localparam logic signed [AVG_W-1:0]  IDLE_DB16    = -12'sd960;

    // EMA of about 0.1: (|d| * 205 + 1024) >> 11
    localparam int EMA_GAIN  = 205;
    localparam int EMA_ROUND = 1024;
    localparam int EMA_SHIFT = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNAP_MODE       = 3'd0,
        CFG_CLIP_HOLD_TICKS = 3'd1,
        CFG_TARGET_LOW_DB   = 3'd2,
        CFG_TARGET_HIGH_DB  = 3'd3,
        CFG_ROUTING_READOUT = 3'd4
    } plmb_cfg_idx_t;

    typedef struct packed {
        logic              snap_mode;
        logic [7:0]        clip_hold_ticks;
        logic signed [6:0] target_low_db;
        logic signed [6:0] target_high_db;
        logic              routing_readout;
    } plmb_cfg_t;

    localparam plmb_cfg_t CFG_RESET = '{
        snap_mode:       1'b0,
        clip_hold_ticks: 8'd45,
        target_low_db:   -7'sd18,
        target_high_db:  -7'sd12,
        routing_readout: 1'b0
    };

    // Status tag codes
    typedef enum logic [2:0] {
        TAG_CLIP    = 3'd0,
        TAG_ROUTING = 3'd1,
        TAG_IN_BAND = 3'd2,
        TAG_IDLE    = 3'd3,
        TAG_LOW     = 3'd4,
        TAG_HOT     = 3'd5
    } plmb_tag_t;

    // Per-stage load strobes, one per pipeline register bank
    typedef struct packed {
        logic hold;   // level/clip state
        logic conv;   // log lookup and partial products
        logic db;     // instant dB
        logic avg;    // smoothed dB state
        logic rpt;    // result register
    } plmb_load_t;

    typedef logic [TAB_SIZE-1:0][LOG_FRAC_BITS-1:0] log_tab_t;

    // log2(1 + i/2^b) in Q30 by repeated squaring, truncated to Q20
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] x;
        logic [30:0] y;
        for (int i = 0; i < TAB_SIZE; i++) begin
            x = 64'(TAB_SIZE + i) << (30 - TAB_BITS);
            y = '0;
            for (int k = 1; k <= 30; k++) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    y[30-k] = 1'b1;
                end
            end
            tab[i] = y[29:10];
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

    // Clamp a widened dB value into the average range
    function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [INST_W:0] v);
        logic signed [INST_W:0] hi;
        logic signed [INST_W:0] lo;
        hi = (INST_W+1)'(2047);
        lo = -(INST_W+1)'(2048);
        if (v > hi)
            return AVG_W'(hi);
        else if (v < lo)
            return AVG_W'(lo);
        else
            return AVG_W'(v);
    endfunction

endpackage

### rtl/plmb_if.sv
// Valid/ready channel interfaces for the meter input tick and result reading.
// Depends on plmb_pkg for the default level width and the dB average width.
interface plmb_in_if
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] peak_level;
    logic                  clip_flag;

    modport source (output valid, peak_level, clip_flag, input ready);
    modport sink   (input valid, peak_level, clip_flag, output ready);
endinterface

interface plmb_out_if
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
);
    logic                    valid;
    logic                    ready;
    logic [LEVEL_BITS-1:0]   held_level;
    logic                    clip_latched;
    logic signed [AVG_W-1:0] smoothed_db;
    logic signed [7:0]       rounded_db;
    logic [2:0]              status_tag;

    modport source (output valid, held_level, clip_latched, smoothed_db, rounded_db,
                    status_tag, input ready);
    modport sink   (input valid, held_level, clip_latched, smoothed_db, rounded_db,
                    status_tag, output ready);
endinterface

### rtl/plmb_hold.sv
// Peak hold with 4/5 decay and the clip latch with its hold counter.
// Depends on plmb_pkg (config and load structs).
module plmb_hold
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  plmb_load_t            ld,
    input  plmb_cfg_t             cfg,
    input  logic [LEVEL_BITS-1:0] peak_level,
    input  logic                  clip_flag,
    output logic [LEVEL_BITS-1:0] held_level,
    output logic                  clip_latched
);

    localparam int          XW          = LEVEL_BITS + 2;
    localparam logic [63:0] DIV5_FULL   = (64'd1 << XW) / 5;
    localparam logic [XW-3:0] DIV5_RECIP = DIV5_FULL[XW-3:0];

    logic [LEVEL_BITS-1:0] level_hold_reg, level_hold_next;
    logic                  clip_state_reg, clip_state_next;
    logic [7:0]            hold_counter_reg, hold_counter_next;

    logic [XW-1:0]         dec_x;
    logic [2*XW-3:0]       dec_prod;
    logic [LEVEL_BITS-1:0] dec_q0;
    logic [XW-1:0]         dec_rem;
    logic [LEVEL_BITS-1:0] decayed;

    // floor(4L/5): reciprocal multiply, then one correction step
    always_comb
    begin
        dec_x    = {level_hold_reg, 2'b00};
        dec_prod = (2*XW-2)'(dec_x) * (2*XW-2)'(DIV5_RECIP);
        dec_q0   = dec_prod[2*XW-3:XW];
        dec_rem  = dec_x - ({dec_q0, 2'b00} + XW'(dec_q0));
        decayed  = (dec_rem >= XW'(5)) ? dec_q0 + LEVEL_BITS'(1) : dec_q0;
    end

    // Level follow/decay and clip latch update
    always_comb
    begin
        if (cfg.snap_mode)
            level_hold_next = peak_level;
        else
            level_hold_next = (peak_level > decayed) ? peak_level : decayed;

        clip_state_next   = clip_state_reg;
        hold_counter_next = hold_counter_reg;
        if (clip_flag)
        begin
            clip_state_next   = 1'b1;
            hold_counter_next = cfg.clip_hold_ticks;
        end
        else if (hold_counter_reg != 8'd0)
        begin
            hold_counter_next = hold_counter_reg - 8'd1;
            if (hold_counter_reg == 8'd1)
                clip_state_next = 1'b0;
        end

        // silence clears the latch at once
        if (level_hold_next == '0)
        begin
            clip_state_next   = 1'b0;
            hold_counter_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_hold_reg   <= '0;
            clip_state_reg   <= 1'b0;
            hold_counter_reg <= 8'd0;
        end
        else if (ld.hold)
        begin
            level_hold_reg   <= level_hold_next;
            clip_state_reg   <= clip_state_next;
            hold_counter_reg <= hold_counter_next;
        end
    end

    assign held_level   = level_hold_reg;
    assign clip_latched = clip_state_reg;

    // Latch never survives silence
    a_latch_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        clip_state_reg |-> (level_hold_reg != '0))
        else $error("clip latch set while held level is zero");

    // A running hold counter implies the latch is set
    a_counter_implies_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_counter_reg != 8'd0) |-> clip_state_reg)
        else $error("hold counter running with latch clear");

    // A clip on a nonzero level always latches
    a_clip_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (ld.hold && clip_flag && (level_hold_next != '0)) |=> clip_state_reg)
        else $error("clip on audible level did not latch");

endmodule

### rtl/plmb_db.sv
// Linear level to 1/16 dB: leading-one search, log2 table, scaled by a
// split constant multiply over two register stages. Depends on plmb_pkg.
module plmb_db
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
)
(
    input  logic                     clk,
    input  plmb_load_t               ld,
    input  logic [LEVEL_BITS-1:0]    held_level_in,
    input  logic                     clip_in,
    output logic signed [INST_W-1:0] inst_db,
    output logic [LEVEL_BITS-1:0]    held_level,
    output logic                     clip_latched
);

    localparam int EW   = $clog2(LEVEL_BITS);
    localparam int VW   = EW + 1 + LOG_FRAC_BITS;
    localparam int PHW  = VW + 16;
    localparam int PLW  = VW + 17;
    localparam int PW   = VW + 32;

    localparam logic signed [15:0] K_HI     = {1'b0, DB_SCALE[30:16]};
    localparam logic signed [16:0] K_LO     = {1'b0, DB_SCALE[15:0]};
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (DB_SHIFT - 1);

    logic [EW-1:0]            msb_pos;
    logic [EW-1:0]            norm_shift;
    logic [LEVEL_BITS-1:0]    norm;
    logic [TAB_BITS-1:0]      tab_idx;
    logic signed [EW:0]       exp_off;
    logic signed [VW-1:0]     log2_val;

    logic signed [PHW-1:0]    prod_hi_reg;
    logic signed [PLW-1:0]    prod_lo_reg;
    logic                     silent_reg;
    logic [LEVEL_BITS-1:0]    level_c_reg;
    logic                     clip_c_reg;

    logic signed [PW-1:0]     db_sum;
    logic signed [PW-1:0]     db_shifted;
    logic signed [INST_W-1:0] inst_next;

    logic signed [INST_W-1:0] inst_reg;
    logic [LEVEL_BITS-1:0]    level_d_reg;
    logic                     clip_d_reg;

    // Leading one, normalize, table index and Q20 log2
    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < LEVEL_BITS; i++)
        begin
            if (held_level_in[i])
                msb_pos = EW'(i);
        end
        norm_shift = EW'(LEVEL_BITS - 1) - msb_pos;
        norm       = held_level_in << norm_shift;
        tab_idx    = norm[LEVEL_BITS-2 -: TAB_BITS];
        exp_off    = (EW+1)'(msb_pos) - (EW+1)'(LEVEL_BITS - 1);
        log2_val   = {exp_off, LOG_TAB[tab_idx]};
    end

    // Stage: partial products of the dB scale
    always_ff @(posedge clk)
    begin
        if (ld.conv)
        begin
            prod_hi_reg <= PHW'(log2_val) * PHW'(K_HI);
            prod_lo_reg <= PLW'(log2_val) * PLW'(K_LO);
            silent_reg  <= (held_level_in == '0);
            level_c_reg <= held_level_in;
            clip_c_reg  <= clip_in;
        end
    end

    // Recombine, round half up, silence floor
    always_comb
    begin
        db_sum     = (PW'(prod_hi_reg) <<< 16) + PW'(prod_lo_reg) + HALF_LSB;
        db_shifted = db_sum >>> DB_SHIFT;
        inst_next  = silent_reg ? SILENCE_DB16 : db_shifted[INST_W-1:0];
    end

    // Stage: instant dB
    always_ff @(posedge clk)
    begin
        if (ld.db)
        begin
            inst_reg    <= inst_next;
            level_d_reg <= level_c_reg;
            clip_d_reg  <= clip_c_reg;
        end
    end

    assign inst_db      = inst_reg;
    assign held_level   = level_d_reg;
    assign clip_latched = clip_d_reg;

endmodule

### rtl/plmb_ema.sv
// dB smoothing (EMA state), whole-dB rounding and status tag, plus the
// result register. Depends on plmb_pkg.
module plmb_ema
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  plmb_load_t               ld,
    input  plmb_cfg_t                cfg,
    input  logic signed [INST_W-1:0] inst_db,
    input  logic [LEVEL_BITS-1:0]    held_level_in,
    input  logic                     clip_in,
    output logic [LEVEL_BITS-1:0]    held_level,
    output logic                     clip_latched,
    output logic signed [AVG_W-1:0]  smoothed_db,
    output logic signed [7:0]        rounded_db,
    output logic [2:0]               status_tag
);

    localparam int SCW    = INST_W + 9;
    localparam int STEP_W = SCW - EMA_SHIFT;

    logic signed [AVG_W-1:0]  db_average_reg, db_average_next;
    logic [LEVEL_BITS-1:0]    level_a_reg;
    logic                     clip_a_reg;

    logic signed [INST_W:0]   diff;
    logic [INST_W-1:0]        mag;
    logic [SCW-1:0]           scaled;
    logic [STEP_W-1:0]        step;
    logic signed [INST_W:0]   step_s;
    logic signed [INST_W:0]   ema_sum;

    logic signed [AVG_W-1:0]  low16;
    logic signed [AVG_W-1:0]  high16;
    logic signed [AVG_W:0]    rnd_sum;
    logic signed [AVG_W:0]    rnd_shift;
    plmb_tag_t                tag_next;

    logic [LEVEL_BITS-1:0]    level_r_reg;
    logic                     clip_r_reg;
    logic signed [AVG_W-1:0]  smoothed_r_reg;
    logic signed [7:0]        rounded_r_reg;
    plmb_tag_t                tag_r_reg;

    // EMA step, or snap straight to the instant value
    always_comb
    begin
        diff    = (INST_W+1)'(inst_db) - (INST_W+1)'(db_average_reg);
        mag     = diff[INST_W] ? INST_W'(-diff) : INST_W'(diff);
        scaled  = SCW'(mag) * SCW'(EMA_GAIN) + SCW'(EMA_ROUND);
        step    = scaled[SCW-1:EMA_SHIFT];
        step_s  = $signed((INST_W+1)'(step));
        ema_sum = (INST_W+1)'(db_average_reg) + (diff[INST_W] ? -step_s : step_s);
        if (cfg.snap_mode)
            db_average_next = sat_avg((INST_W+1)'(inst_db));
        else
            db_average_next = sat_avg(ema_sum);
    end

    // Stage: smoothed dB state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            db_average_reg <= '0;
        else if (ld.avg)
            db_average_reg <= db_average_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld.avg)
        begin
            level_a_reg <= held_level_in;
            clip_a_reg  <= clip_in;
        end
    end

    // Rounding and band classification on the updated average
    always_comb
    begin
        low16     = AVG_W'($signed({cfg.target_low_db, 4'd0}));
        high16    = AVG_W'($signed({cfg.target_high_db, 4'd0}));
        rnd_sum   = (AVG_W+1)'(db_average_reg) + (AVG_W+1)'(8);
        rnd_shift = rnd_sum >>> 4;

        if (clip_a_reg)
            tag_next = TAG_CLIP;
        else if (cfg.routing_readout)
            tag_next = TAG_ROUTING;
        else if (db_average_reg >= low16 && db_average_reg <= high16)
            tag_next = TAG_IN_BAND;
        else if (db_average_reg < IDLE_DB16)
            tag_next = TAG_IDLE;
        else if (db_average_reg < low16)
            tag_next = TAG_LOW;
        else
            tag_next = TAG_HOT;
    end

    // Stage: result register
    always_ff @(posedge clk)
    begin
        if (ld.rpt)
        begin
            level_r_reg    <= level_a_reg;
            clip_r_reg     <= clip_a_reg;
            smoothed_r_reg <= db_average_reg;
            rounded_r_reg  <= rnd_shift[7:0];
            tag_r_reg      <= tag_next;
        end
    end

    assign held_level   = level_r_reg;
    assign clip_latched = clip_r_reg;
    assign smoothed_db  = smoothed_r_reg;
    assign rounded_db   = rounded_r_reg;
    assign status_tag   = tag_r_reg;

endmodule

### rtl/peak_level_meter_ballistics_core.sv
// Peak level meter with clip hold: each accepted tick gives one result beat;
// throughput one tick per cycle when not stalled. Five register stages (hold,
// partial products, instant dB, smoothed dB, result); a stage takes a new
// beat whenever it is empty or passing its own on, so a waiting result
// stalls only a full pipe. Async active-low reset clears config to defaults,
// the hold, latch, counter and dB average to zero, and empties the pipe.
module peak_level_meter_ballistics_core
    import plmb_pkg::*;
#(
    parameter int LEVEL_BITS = PLMB_LEVEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    plmb_in_if.sink               tick,
    plmb_out_if.source            reading,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 5;

    plmb_cfg_t        cfg_reg, cfg_next;
    logic [NSTG-1:0]  vld_reg, vld_next;
    logic [NSTG-1:0]  load;
    logic [NSTG-1:0]  free;
    plmb_load_t       ld;

    logic [LEVEL_BITS-1:0]    hold_level;
    logic                     hold_clip;
    logic [LEVEL_BITS-1:0]    db_level;
    logic                     db_clip;
    logic signed [INST_W-1:0] inst_db;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SNAP_MODE:       cfg_next.snap_mode       = cfg_data[0];
                CFG_CLIP_HOLD_TICKS: cfg_next.clip_hold_ticks = cfg_data[7:0];
                CFG_TARGET_LOW_DB:   cfg_next.target_low_db   = $signed(cfg_data[6:0]);
                CFG_TARGET_HIGH_DB:  cfg_next.target_high_db  = $signed(cfg_data[6:0]);
                CFG_ROUTING_READOUT: cfg_next.routing_readout = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Stage flow: a stage is free if empty or handing its beat on
    always_comb
    begin
        free[NSTG-1] = !vld_reg[NSTG-1] || reading.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k+1] = vld_reg[k] && free[k+1];
            free[k]   = !vld_reg[k] || load[k+1];
        end
        load[0] = tick.valid && free[0];

        for (int k = 0; k < NSTG - 1; k++)
            vld_next[k] = load[k] || (vld_reg[k] && !load[k+1]);
        vld_next[NSTG-1] = load[NSTG-1] || (vld_reg[NSTG-1] && !reading.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign ld.hold = load[0];
    assign ld.conv = load[1];
    assign ld.db   = load[2];
    assign ld.avg  = load[3];
    assign ld.rpt  = load[4];

    assign tick.ready    = free[0];
    assign reading.valid = vld_reg[NSTG-1];

    plmb_hold #(
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_hold (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld           (ld),
        .cfg          (cfg_reg),
        .peak_level   (tick.peak_level),
        .clip_flag    (tick.clip_flag),
        .held_level   (hold_level),
        .clip_latched (hold_clip)
    );

    plmb_db #(
        .LEVEL_BITS    (LEVEL_BITS)
    ) u_db (
        .clk           (clk),
        .ld            (ld),
        .held_level_in (hold_level),
        .clip_in       (hold_clip),
        .inst_db       (inst_db),
        .held_level    (db_level),
        .clip_latched  (db_clip)
    );

    plmb_ema #(
        .LEVEL_BITS    (LEVEL_BITS)
    ) u_ema (
        .clk           (clk),
        .rst_n         (rst_n),
        .ld            (ld),
        .cfg           (cfg_reg),
        .inst_db       (inst_db),
        .held_level_in (db_level),
        .clip_in       (db_clip),
        .held_level    (reading.held_level),
        .clip_latched  (reading.clip_latched),
        .smoothed_db   (reading.smoothed_db),
        .rounded_db    (reading.rounded_db),
        .status_tag    (reading.status_tag)
    );

    // Back-pressure reaches the input only when every stage holds a beat
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipe");

    // A latched clip always reports the clip tag
    a_clip_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (reading.valid && reading.clip_latched) |-> (reading.status_tag == TAG_CLIP))
        else $error("clip latched but tag is not clip");

    // A beat accepted into an empty pipe reaches the output with no stall on the way
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (load[0] && (vld_reg == '0)) |-> ##5 reading.valid)
        else $error("result beat missing after pipeline latency");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for peak_level_meter_ballistics_core: a cycle-free
// predictor of the meter ballistics checks every result beat in order.
// Depends on rtl/plmb_pkg.sv, rtl/plmb_if.sv and the core itself.
module testbench;
    import plmb_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LEVEL_W      = PLMB_LEVEL_BITS;
    localparam int MAX_REPORTS  = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_ROUTING_READOUT + 1);

    typedef struct packed {
        logic [LEVEL_W-1:0]      held;
        logic                    latch;
        logic signed [AVG_W-1:0] db16;
        logic signed [7:0]       db;
        plmb_tag_t               tag;
    } reading_t;

    // Shapes of random tick bursts
    typedef enum int {
        BURST_SILENCE,
        BURST_QUIET,
        BURST_ANY,
        BURST_LOUD,
        BURST_MID,
        BURST_SPIKE
    } burst_kind_t;

    // Meter ballistics: held level, clip latch, dB average and the readings they give
    class ballistics_calc;
        bit                 snap;
        bit [7:0]           hold_ticks;
        int                 low_db;
        int                 high_db;
        bit                 routing;
        bit [LEVEL_W-1:0]   level;
        bit                 latch;
        bit [7:0]           countdown;
        int                 avg;
        int unsigned        log_frac[TAB_SIZE];
        reading_t           pending_readings[$];
        int                 errors;
        int                 beats;

        function new();
            longint unsigned x;
            int unsigned     y;
            snap       = 1'b0;
            hold_ticks = 8'd45;
            low_db     = -18;
            high_db    = -12;
            routing    = 1'b0;
            level      = '0;
            latch      = 1'b0;
            countdown  = '0;
            avg        = 0;
            errors     = 0;
            beats      = 0;
            // log2(1 + i/2^b): square the mantissa, each overflow gives one bit
            for (int i = 0; i < TAB_SIZE; i++)
            begin
                x = longint'(TAB_SIZE + i) << (30 - TAB_BITS);
                y = 0;
                for (int k = 29; k >= 0; k--)
                begin
                    x = (x * x) >> 30;
                    if (x >= (64'd1 << 31))
                    begin
                        x = x >> 1;
                        y[k] = 1'b1;
                    end
                end
                log_frac[i] = y >> (30 - LOG_FRAC_BITS);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SNAP_MODE:       snap = data[0];
                CFG_CLIP_HOLD_TICKS: hold_ticks = data[7:0];
                CFG_TARGET_LOW_DB:   low_db = int'($signed(data[6:0]));
                CFG_TARGET_HIGH_DB:  high_db = int'($signed(data[6:0]));
                CFG_ROUTING_READOUT: routing = data[0];
                default: ;
            endcase
        endfunction

        function int clamp_avg(int v);
            if (v > 2047)
                return 2047;
            if (v < -2048)
                return -2048;
            return v;
        endfunction

        // Instant level in 1/16 dB
        function int level_db16(bit [LEVEL_W-1:0] lvl);
            int          msb;
            int unsigned l32;
            int unsigned idx;
            longint      v;
            if (lvl == 0)
                return int'(SILENCE_DB16);
            l32 = lvl;
            msb = 0;
            for (int b = 0; b < LEVEL_W; b++)
                if (lvl[b])
                    msb = b;
            if (msb >= TAB_BITS)
                idx = (l32 >> (msb - TAB_BITS)) & (TAB_SIZE - 1);
            else
                idx = (l32 << (TAB_BITS - msb)) & (TAB_SIZE - 1);
            v = longint'(msb - (LEVEL_W - 1)) * (64'sd1 <<< LOG_FRAC_BITS)
                + longint'(log_frac[idx]);
            return int'((v * longint'(DB_SCALE) + (64'sd1 <<< (DB_SHIFT - 1))) >>> DB_SHIFT);
        endfunction

        function void take_tick(bit [LEVEL_W-1:0] peak, bit clip);
            bit [LEVEL_W-1:0] decayed;
            int               inst;
            int               diff;
            int               stepv;
            reading_t         r;
            // peak hold with 4/5 decay, or follow in snap mode
            if (snap)
                level = peak;
            else
            begin
                decayed = LEVEL_W'((32'(level) * 4) / 5);
                level = (peak > decayed) ? peak : decayed;
            end
            // clip latch and hold countdown; silence clears both
            if (clip)
            begin
                latch = 1'b1;
                countdown = hold_ticks;
            end
            else if (countdown != 0)
            begin
                countdown--;
                if (countdown == 0)
                    latch = 1'b0;
            end
            if (level == 0)
            begin
                latch = 1'b0;
                countdown = '0;
            end
            // dB smoothing
            inst = level_db16(level);
            if (snap)
                avg = clamp_avg(inst);
            else
            begin
                diff = inst - avg;
                stepv = ((diff < 0 ? -diff : diff) * EMA_GAIN + EMA_ROUND) >>> EMA_SHIFT;
                avg = clamp_avg(avg + (diff < 0 ? -stepv : stepv));
            end
            r.held  = level;
            r.latch = latch;
            r.db16  = AVG_W'(avg);
            r.db    = 8'((avg + 8) >>> 4);
            if (latch)
                r.tag = TAG_CLIP;
            else if (routing)
                r.tag = TAG_ROUTING;
            else if (avg >= low_db * 16 && avg <= high_db * 16)
                r.tag = TAG_IN_BAND;
            else if (avg < int'(IDLE_DB16))
                r.tag = TAG_IDLE;
            else if (avg < low_db * 16)
                r.tag = TAG_LOW;
            else
                r.tag = TAG_HOT;
            pending_readings.push_back(r);
        endfunction

        function void match_reading(reading_t got);
            reading_t want;
            beats++;
            if (pending_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: reading beat %0d with no tick behind it", $realtime, beats);
                return;
            end
            want = pending_readings.pop_front();
            if (got.held !== want.held || got.latch !== want.latch || got.db16 !== want.db16
                || got.db !== want.db || got.tag !== want.tag)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: beat %0d mismatch (exp/got): held %0d/%0d latch %0b/%0b ",
                              "db16 %0d/%0d db %0d/%0d tag %0d/%0d"}, $realtime, beats,
                             want.held, got.held, want.latch, got.latch, want.db16, got.db16,
                             want.db, got.db, want.tag, got.tag);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    ballistics_calc        ballistics;

    plmb_in_if  tick_if ();
    plmb_out_if reading_if ();

    peak_level_meter_ballistics_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_if),
        .reading   (reading_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: check accepted beats, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && reading_if.valid && reading_if.ready)
            ballistics.match_reading('{held:  reading_if.held_level,
                                       latch: reading_if.clip_latched,
                                       db16:  reading_if.smoothed_db,
                                       db:    reading_if.rounded_db,
                                       tag:   plmb_tag_t'(reading_if.status_tag)});
        reading_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One tick beat, with random idle cycles in front of it
    task automatic send_tick(input logic [LEVEL_W-1:0] peak, input logic clip);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.peak_level <= peak;
        tick_if.clip_flag  <= clip;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        ballistics.take_tick(peak, clip);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        ballistics.write_reg(idx, data);
    endtask

    task automatic set_config(input int snap, input int hold, input int low, input int high,
                              input int routing);
        write_reg(CFG_SNAP_MODE, CFG_DATA_W'(snap));
        write_reg(CFG_CLIP_HOLD_TICKS, CFG_DATA_W'(hold));
        write_reg(CFG_TARGET_LOW_DB, CFG_DATA_W'(low));
        write_reg(CFG_TARGET_HIGH_DB, CFG_DATA_W'(high));
        write_reg(CFG_ROUTING_READOUT, CFG_DATA_W'(routing));
        cfg_we <= 1'b0;
    endtask

    // Hold off the sender until every reading is back
    task automatic drain();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (ballistics.pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Bursts of related ticks so the hold, decay and latch timers all run out
    task automatic run_random(input int count);
        int               sent;
        int               len;
        int               clip_pct;
        burst_kind_t      kind;
        logic [LEVEL_W-1:0] peak;
        sent = 0;
        while (sent < count)
        begin
            kind = burst_kind_t'($urandom_range(BURST_SPIKE));
            len  = $urandom_range(1, 40);
            case ($urandom_range(2))
                0:       clip_pct = 0;
                1:       clip_pct = 4;
                default: clip_pct = 40;
            endcase
            for (int j = 0; j < len && sent < count; j++)
            begin
                case (kind)
                    BURST_SILENCE: peak = '0;
                    BURST_QUIET:   peak = LEVEL_W'($urandom_range(1, 15));
                    BURST_LOUD:    peak = LEVEL_W'($urandom_range(30000, 65535));
                    BURST_MID:     peak = LEVEL_W'($urandom_range(16, 4095));
                    BURST_SPIKE:   peak = (j == 0) ? LEVEL_W'($urandom) : '0;
                    default:       peak = LEVEL_W'($urandom);
                endcase
                send_tick(peak, $urandom_range(99) < clip_pct);
                sent++;
            end
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 60;
            default: return 19;
        endcase
    endfunction

    initial
    begin
        ballistics         = new;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        tick_if.valid      = 1'b0;
        tick_if.peak_level = '0;
        tick_if.clip_flag  = 1'b0;
        reading_if.ready   = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: silence, clip on silence, full scale, MSB boundaries
        send_tick(16'd0, 1'b0);
        send_tick(16'd0, 1'b1);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'h8000, 1'b0);
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'd1, 1'b1);
        send_tick(16'd0, 1'b0);
        send_tick(16'd2, 1'b0);
        send_tick(16'd3, 1'b0);
        send_tick(16'd64, 1'b0);
        send_tick(16'd65, 1'b1);
        send_tick(16'd127, 1'b0);
        send_tick(16'd128, 1'b0);
        send_tick(16'h5555, 1'b0);
        send_tick(16'hAAAA, 1'b1);
        send_tick(16'd0, 1'b0);
        send_tick(16'd0, 1'b0);
        run_random(100);
        drain();

        // Snap mode, zero hold, widest band; sender idles
        set_config(1, 0, -60, 6, 0);
        send_idle_pct = 60;
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'd40000, 1'b0);
        send_tick(16'd0, 1'b0);
        send_tick(16'd1, 1'b1);
        send_tick(16'h8000, 1'b0);
        run_random(100);
        drain();

        // Longest hold, reversed band, routing readout; spare indexes are ignored
        set_config(0, 255, 6, -60, 1);
        for (int i = CFG_FIRST_UNUSED; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        run_random(100);
        drain();

        // Shortest hold, single-point band; both sides idle, one full pause
        set_config(0, 1, -60, -60, 0);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        run_random(50);
        drain();
        run_random(50);
        drain();

        // Zero hold with decay, mid band; back to back
        set_config(0, 0, -30, 0, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(100);
        drain();

        // Random raw register data, random pacing
        repeat (2)
        begin
            set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
            send_idle_pct  = pick_pct();
            recv_stall_pct = pick_pct();
            run_random(60);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (ballistics.errors == 0 && ballistics.pending_readings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/plmb_pkg.sv
rtl/plmb_if.sv
rtl/plmb_hold.sv
rtl/plmb_db.sv
rtl/plmb_ema.sv
rtl/peak_level_meter_ballistics_core.sv
test/testbench.sv
